@@ src/pva_pkg.sv @@
package pva_pkg;

    // Default table size
    localparam int NUM_VOICES_DEF = 16;
    localparam int MAX_VOICES     = 64;

    // Field widths
    localparam int OP_W     = 2;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int FREQ_W   = 23;
    localparam int FRAME_W  = 32;
    localparam int VIDX_W   = 6;
    localparam int OCT_W    = 4;
    localparam int STEP_W   = 4;
    localparam int BASE_W   = 29;
    localparam int SCALED_W = 40;
    localparam int FRAC_CUT = 16;

    // Stream widths
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = OP_W;
    localparam int OUT_DATA_W = 40;

    // Item kinds
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } op_t;

    // One voice entry as kept in the voice RAM
    typedef struct packed {
        logic [FRAME_W-1:0] start;
        logic [FREQ_W-1:0]  freq;
        logic [VEL_W-1:0]   velocity;
        logic [NOTE_W-1:0]  note;
    } voice_word_t;

    localparam int VOICE_WORD_W = $bits(voice_word_t);

    // Frequency of notes 0..11 in Hz, 24 fraction bits
    function automatic logic [BASE_W-1:0] base_freq(input logic [STEP_W-1:0] step);
        logic [BASE_W-1:0] val;
        begin
            case (step)
                4'd0:    val = 29'd274334289;
                4'd1:    val = 29'd290647054;
                4'd2:    val = 29'd307929828;
                4'd3:    val = 29'd326240288;
                4'd4:    val = 29'd345639545;
                4'd5:    val = 29'd366192342;
                4'd6:    val = 29'd387967272;
                4'd7:    val = 29'd411037006;
                4'd8:    val = 29'd435478539;
                4'd9:    val = 29'd461373440;
                4'd10:   val = 29'd488808132;
                4'd11:   val = 29'd517874176;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

    // Octave of a note: n/12 as (n*171)>>11, exact for n below 128
    function automatic logic [OCT_W-1:0] note_octave(input logic [NOTE_W-1:0] n);
        logic [14:0] prod;
        begin
            prod = 15'(n) * 15'd171;
            return prod[14:11];
        end
    endfunction

    // Scale the base frequency by the octave and round to 8 fraction bits
    function automatic logic [FREQ_W-1:0] note_freq(input logic [OCT_W-1:0] oct,
                                                    input logic [STEP_W-1:0] step);
        logic [SCALED_W-1:0] scaled;
        begin
            scaled = (SCALED_W'(base_freq(step)) << oct) + SCALED_W'(32768);
            return scaled[FRAC_CUT +: FREQ_W];
        end
    endfunction

endpackage

@@ src/pva_ram.sv @@
module pva_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/poly_voice_allocator_unit.sv @@
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+------------------------------------------
// input    | s_axis_tvalid/s_axis_tready | tuser: op; tdata: note, velocity
// output   | m_axis_tvalid/m_axis_tready | tdata: voice fields; tlast: last voice
//
// One voice is visited per cycle through the single read port of the voice RAM, unless a tick waits on the output.
// A tick visits every voice, a note-on scans every voice and then writes the chosen one,
// a note-off stops at the first match; input is not ready while an item is being worked on.
// Reset clears the frame counter, gates, triggers and per-voice valid bits; a voice
// never written reads as all zero, so the RAM needs no clearing pass.
// A tick waits on the output register when the output side stalls.
module poly_voice_allocator_unit #(
    parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [6:0] note_number, [13:7] note_velocity, [15:14] zero
    input  logic [pva_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [pva_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [5:0] voice_num, [6] gate, [7] trigger, [14:8] velocity_level,
    // [37:15] frequency, [39:38] zero
    output logic [pva_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);

    import pva_pkg::*;

    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_ON_SCAN,
        ST_ON_WRITE,
        ST_OFF_SCAN
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [NOTE_W-1:0]       note_reg, note_next;
    logic [VEL_W-1:0]        vel_reg, vel_next;
    logic [OCT_W-1:0]        oct_reg, oct_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [FREQ_W-1:0]       freq_reg, freq_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [FRAME_W-1:0]      best_age_reg, best_age_next;
    logic [FRAME_W-1:0]      frame_reg, frame_next;
    logic [NUM_VOICES-1:0]   gate_reg, gate_next;
    logic [NUM_VOICES-1:0]   trig_reg, trig_next;
    logic [NUM_VOICES-1:0]   valid_reg, valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;

    logic                    ram_we;
    logic [VOICE_WORD_W-1:0] ram_wdata;
    logic [VOICE_WORD_W-1:0] ram_rdata;
    voice_word_t             cur;
    voice_word_t             wr_word;
    logic [FRAME_W-1:0]      cur_age;
    logic                    out_free;
    logic                    in_accept;
    logic                    is_last;

    // Voice table: read address follows the next index, so data matches idx_reg
    pva_ram #(
        .WIDTH (VOICE_WORD_W),
        .DEPTH (NUM_VOICES),
        .ADDR_W(IDX_W)
    ) u_voice_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(best_reg),
        .wdata(ram_wdata),
        .raddr(idx_next),
        .rdata(ram_rdata)
    );

    // Mask entries never written to their reset value
    always_comb
    begin
        cur = valid_reg[idx_reg] ? voice_word_t'(ram_rdata) : '0;
        cur_age = frame_reg - cur.start;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_last       = (idx_reg == LAST_IDX);

    always_comb
    begin
        wr_word.start    = frame_reg;
        wr_word.freq     = freq_reg;
        wr_word.velocity = vel_reg;
        wr_word.note     = note_reg;
        ram_wdata        = wr_word;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        note_next      = note_reg;
        vel_next       = vel_reg;
        oct_next       = oct_reg;
        step_next      = step_reg;
        freq_next      = freq_reg;
        best_next      = best_reg;
        best_age_next  = best_age_reg;
        frame_next     = frame_reg;
        gate_next      = gate_reg;
        trig_next      = trig_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;

        // Drop the output transaction once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    note_next = s_axis_tdata[NOTE_W-1:0];
                    vel_next  = s_axis_tdata[NOTE_W +: VEL_W];
                    oct_next  = note_octave(s_axis_tdata[NOTE_W-1:0]);
                    step_next = STEP_W'(s_axis_tdata[NOTE_W-1:0]
                                - NOTE_W'(12) * NOTE_W'(note_octave(s_axis_tdata[NOTE_W-1:0])));
                    idx_next  = '0;
                    unique case (op_t'(s_axis_tuser))
                        OP_TICK:     state_next = ST_TICK;
                        OP_NOTE_ON:  state_next = ST_ON_SCAN;
                        OP_NOTE_OFF: state_next = ST_OFF_SCAN;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end

            ST_TICK:
            begin
                // Emit one voice whenever the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = is_last;
                    out_data_next  = {2'b00, cur.freq, cur.velocity, trig_reg[idx_reg],
                                      gate_reg[idx_reg], VIDX_W'(idx_reg)};
                    trig_next[idx_reg] = 1'b0;
                    if (is_last)
                    begin
                        frame_next = frame_reg + FRAME_W'(1);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_ON_SCAN:
            begin
                freq_next = note_freq(oct_reg, step_reg);
                // Keep the oldest voice, lowest index on ties
                if (idx_reg == '0 || cur_age > best_age_reg)
                begin
                    best_next     = idx_reg;
                    best_age_next = cur_age;
                end
                if (is_last)
                begin
                    state_next = ST_ON_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_ON_WRITE:
            begin
                ram_we               = 1'b1;
                valid_next[best_reg] = 1'b1;
                gate_next[best_reg]  = 1'b1;
                trig_next[best_reg]  = 1'b1;
                state_next           = ST_IDLE;
            end

            ST_OFF_SCAN:
            begin
                // Release the first gated voice holding the note
                if (gate_reg[idx_reg] && cur.note == note_reg)
                begin
                    gate_next[idx_reg] = 1'b0;
                    state_next         = ST_IDLE;
                end
                else if (is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            frame_reg     <= '0;
            gate_reg      <= '0;
            trig_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            frame_reg     <= frame_next;
            gate_reg      <= gate_next;
            trig_reg      <= trig_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        note_reg     <= note_next;
        vel_reg      <= vel_next;
        oct_reg      <= oct_next;
        step_reg     <= step_next;
        freq_reg     <= freq_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ tb/tb_poly_voice_allocator_unit.sv @@
module tb_poly_voice_allocator_unit;

    import pva_pkg::*;

    localparam int VOICES        = NUM_VOICES_DEF;
    localparam int HOLD_AT_ITEM  = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_AT_ITEM = 200;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 2 * VOICES + 8;
    localparam int MAX_REPORTS   = 100;

    // Op code that the block has no use for
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // Notes 0..11 in Hz with 24 fraction bits
    localparam logic [31:0] SEMITONE_Q24 [12] = '{
        32'd274334289, 32'd290647054, 32'd307929828, 32'd326240288,
        32'd345639545, 32'd366192342, 32'd387967272, 32'd411037006,
        32'd435478539, 32'd461373440, 32'd488808132, 32'd517874176
    };

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        bit                drain;
    } voice_event_t;

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic              gate;
        logic              trig;
        logic [VEL_W-1:0]  vel;
        logic [FREQ_W-1:0] freq;
        logic              last;
    } voice_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Pending events and voice reports still owed by the block
    voice_event_t  event_q[$];
    voice_report_t voice_report_q[$];

    // Predicted voice table
    logic [FRAME_W-1:0] frame_no;
    logic [NOTE_W-1:0]  v_note  [VOICES];
    logic               v_gate  [VOICES];
    logic               v_trig  [VOICES];
    logic [VEL_W-1:0]   v_vel   [VOICES];
    logic [FREQ_W-1:0]  v_freq  [VOICES];
    logic [FRAME_W-1:0] v_start [VOICES];

    int n_offered;
    int n_accepted;
    int n_total;
    int n_errors;
    int n_checked;
    int n_ticks, n_ons, n_offs, n_ignored, n_steals, n_unmatched_offs;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_done;
    bit drain_done;

    poly_voice_allocator_unit #(
        .NUM_VOICES(VOICES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Note number to Hz, 8 fraction bits, halves rounded up
    function automatic logic [FREQ_W-1:0] pitch_to_hz_q8(input logic [NOTE_W-1:0] note);
        logic [63:0] scaled;
        int          octave;
        int          step;
        begin
            octave = int'(note) / 12;
            step   = int'(note) % 12;
            scaled = 64'(SEMITONE_Q24[step]) << octave;
            return FREQ_W'((scaled + 64'd32768) >> FRAC_CUT);
        end
    endfunction

    // Update the voice table for one accepted event and queue any reports
    function automatic void apply_voice_event(input logic [OP_W-1:0]   op,
                                              input logic [NOTE_W-1:0] note,
                                              input logic [VEL_W-1:0]  vel);
        int                 pick;
        logic [FRAME_W-1:0] age;
        logic [FRAME_W-1:0] best_age;
        voice_report_t      rep;
        bit                 found;
        begin
            if (op == OP_NOTE_ON)
            begin
                // Steal the oldest voice, lowest index on a tie
                pick     = 0;
                best_age = frame_no - v_start[0];
                for (int i = 1; i < VOICES; i++)
                begin
                    age = frame_no - v_start[i];
                    if (age > best_age)
                    begin
                        best_age = age;
                        pick     = i;
                    end
                end
                if (v_gate[pick])
                    n_steals++;
                v_note[pick]  = note;
                v_vel[pick]   = vel;
                v_freq[pick]  = pitch_to_hz_q8(note);
                v_gate[pick]  = 1'b1;
                v_trig[pick]  = 1'b1;
                v_start[pick] = frame_no;
                n_ons++;
            end
            else if (op == OP_NOTE_OFF)
            begin
                // Release the lowest gated voice holding the note
                found = 1'b0;
                for (int i = 0; i < VOICES; i++)
                begin
                    if (!found && v_gate[i] && v_note[i] == note)
                    begin
                        v_gate[i] = 1'b0;
                        found     = 1'b1;
                    end
                end
                if (!found)
                    n_unmatched_offs++;
                n_offs++;
            end
            else if (op == OP_TICK)
            begin
                // Report every voice, then clear triggers and advance the frame
                for (int i = 0; i < VOICES; i++)
                begin
                    rep.vidx = VIDX_W'(i);
                    rep.gate = v_gate[i];
                    rep.trig = v_trig[i];
                    rep.vel  = v_vel[i];
                    rep.freq = v_freq[i];
                    rep.last = (i == VOICES - 1);
                    voice_report_q.insert(voice_report_q.size(), rep);
                    v_trig[i] = 1'b0;
                end
                frame_no = frame_no + 1;
                n_ticks++;
            end
            else
            begin
                n_ignored++;
            end
        end
    endfunction

    task automatic add_event(input logic [OP_W-1:0]   op,
                             input logic [NOTE_W-1:0] note,
                             input logic [VEL_W-1:0]  vel,
                             input bit                drain);
        voice_event_t ev;
        begin
            ev.op    = op;
            ev.note  = note;
            ev.vel   = vel;
            ev.drain = drain;
            event_q.insert(event_q.size(), ev);
        end
    endtask

    // Pick idle rates from progress through the run
    always_comb
    begin
        if (n_accepted < n_total / 3)
        begin
            send_idle_pct  = 10;
            recv_stall_pct = 58;
        end
        else if (n_accepted < (2 * n_total) / 3)
        begin
            send_idle_pct  = 58;
            recv_stall_pct = 10;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    end

    // Driver: offer the next event once the previous transaction has gone
    always @(negedge clk)
    begin : event_driver
        bit           busy;
        bit           offer;
        voice_event_t ev;
        busy  = s_axis_tvalid && (n_offered != n_accepted);
        offer = 1'b0;
        if (!busy)
        begin
            if (rst_n && event_q.size() > 0)
            begin
                // Hold a drain event until the block has delivered everything
                if (event_q[0].drain && voice_report_q.size() > 0)
                    offer = 1'b0;
                else if ($urandom_range(99) >= send_idle_pct)
                    offer = 1'b1;
                else
                    offer = 1'b0;
            end
            if (offer)
            begin
                ev = event_q.pop_front();
                if (ev.drain)
                    drain_done = 1'b1;
                s_axis_tdata <= {2'b00, ev.vel, ev.note};
                s_axis_tuser <= ev.op;
                n_offered++;
            end
            s_axis_tvalid <= offer;
        end
    end

    // Receiver: random stalls plus one long hold-off while events keep coming
    always @(negedge clk)
    begin : report_sink
        bit ready;
        if (hold_left > 0)
        begin
            hold_left--;
            ready = 1'b0;
        end
        else if (!hold_done && n_accepted >= HOLD_AT_ITEM)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            ready     = 1'b0;
        end
        else
        begin
            ready = ($urandom_range(99) >= recv_stall_pct);
        end
        m_axis_tready <= ready;
    end

    // Monitor: check reports against the predicted table, feed accepted events
    always @(posedge clk)
    begin : stream_monitor
        voice_report_t got;
        voice_report_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.vidx = m_axis_tdata[5:0];
                got.gate = m_axis_tdata[6];
                got.trig = m_axis_tdata[7];
                got.vel  = m_axis_tdata[14:8];
                got.freq = m_axis_tdata[37:15];
                got.last = m_axis_tlast;
                n_checked++;
                if (voice_report_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                    begin
                        $write("%0t: unexpected report voice=%0d gate=%0b trig=%0b",
                               $time, got.vidx, got.gate, got.trig);
                        $display(" vel=%0d freq=%0d last=%0b",
                                 got.vel, got.freq, got.last);
                    end
                end
                else
                begin
                    want = voice_report_q.pop_front();
                    if (got !== want)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                        begin
                            $write("%0t: mismatch expected voice=%0d gate=%0b trig=%0b",
                                   $time, want.vidx, want.gate, want.trig);
                            $write(" vel=%0d freq=%0d last=%0b",
                                   want.vel, want.freq, want.last);
                            $write(", got voice=%0d gate=%0b trig=%0b",
                                   got.vidx, got.gate, got.trig);
                            $display(" vel=%0d freq=%0d last=%0b",
                                     got.vel, got.freq, got.last);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_accepted++;
                apply_voice_event(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[13:7]);
            end
        end
    end

    // Build the event list, run it and judge the result
    initial
    begin : stimulus
        logic [NOTE_W-1:0] recent[$];
        logic [NOTE_W-1:0] note;
        int                sel;
        int                counted;
        frame_no = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            v_note[i]  = '0;
            v_gate[i]  = 1'b0;
            v_trig[i]  = 1'b0;
            v_vel[i]   = '0;
            v_freq[i]  = '0;
            v_start[i] = '0;
        end

        // Directed: reset table, field extremes, duplicates, misses, filling every voice
        add_event(OP_TICK, 7'd0, 7'd0, 1'b0);
        add_event(OP_NOTE_ON, 7'd0, 7'd0, 1'b0);
        add_event(OP_NOTE_ON, 7'd127, 7'd127, 1'b0);
        add_event(OP_NOTE_ON, 7'd60, 7'd64, 1'b0);
        add_event(OP_NOTE_ON, 7'd60, 7'd100, 1'b0);
        add_event(OP_TICK, 7'd0, 7'd0, 1'b0);
        add_event(OP_NOTE_OFF, 7'd60, 7'd127, 1'b0);
        add_event(OP_NOTE_OFF, 7'd61, 7'd0, 1'b0);
        add_event(OP_NOTE_OFF, 7'd127, 7'd0, 1'b0);
        add_event(OP_RESERVED, 7'd127, 7'd127, 1'b0);
        add_event(OP_TICK, 7'd0, 7'd0, 1'b0);
        for (int i = 0; i < 12; i++)
            add_event(OP_NOTE_ON, NOTE_W'(i * 11), VEL_W'(10 * i + 5), 1'b0);
        add_event(OP_NOTE_OFF, 7'd0, 7'd0, 1'b0);
        add_event(OP_NOTE_OFF, 7'd0, 7'd0, 1'b0);
        add_event(OP_TICK, 7'd0, 7'd0, 1'b0);

        // Random: mostly note-ons and note-offs of held notes, ticks between
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 4)
            begin
                add_event(OP_RESERVED, NOTE_W'($urandom_range(127)),
                          VEL_W'($urandom_range(127)), 1'b0);
            end
            else
            begin
                if (sel < 44)
                begin
                    if ($urandom_range(3) == 0)
                        note = NOTE_W'(60 + $urandom_range(3));
                    else
                        note = NOTE_W'($urandom_range(127));
                    recent.insert(recent.size(), note);
                    if (recent.size() > 12)
                        recent.pop_front();
                    add_event(OP_NOTE_ON, note, VEL_W'($urandom_range(127)),
                              counted == DRAIN_AT_ITEM);
                end
                else if (sel < 68)
                begin
                    if (recent.size() > 0 && $urandom_range(4) != 0)
                        note = recent[$urandom_range(recent.size() - 1)];
                    else
                        note = NOTE_W'($urandom_range(127));
                    add_event(OP_NOTE_OFF, note, VEL_W'($urandom_range(127)),
                              counted == DRAIN_AT_ITEM);
                end
                else
                begin
                    add_event(OP_TICK, NOTE_W'($urandom_range(127)),
                              VEL_W'($urandom_range(127)), counted == DRAIN_AT_ITEM);
                end
                counted++;
            end
        end
        n_total = event_q.size();

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every event to be taken and every report to arrive
        while (event_q.size() > 0 || n_offered != n_accepted)
            @(posedge clk);
        while (voice_report_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $write("Covered %0d events: %0d ticks, %0d note-ons (%0d stole a held voice), ",
               n_accepted, n_ticks, n_ons, n_steals);
        $display("%0d note-offs (%0d unmatched), %0d reserved",
                 n_offs, n_unmatched_offs, n_ignored);
        $display("Checked %0d voice reports; long output stall %0s, drain pause %0s",
                 n_checked, hold_done ? "done" : "missed", drain_done ? "done" : "missed");
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Timeout after %0t with %0d reports outstanding",
                 $time, voice_report_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
